// ===== rtl/trimmed_moving_average_top_macros.svh =====
// Assertion macros for the trimmed moving average block.
// Used by trimmed_moving_average_top.sv; no other dependencies.
`ifndef TRIMMED_MOVING_AVERAGE_TOP_MACROS_SVH
`define TRIMMED_MOVING_AVERAGE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define TMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tma_pkg.sv =====
// Shared constants for the trimmed moving average block.
// No dependencies; used by the interfaces and the top level.
package tma_pkg;

    // Build defaults
    localparam int DEPTH_DEF       = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Window limits and reset length
    localparam int MIN_LENGTH    = 5;
    localparam int TRIMMED_COUNT = 2;
    localparam int RESET_LENGTH  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_WINDOW_LENGTH = 1'd0;
    localparam t_cfg_idx REG_TRIM_MODE     = 1'd1;

endpackage

// ===== rtl/tma_sample_if.sv =====
// Input request channel carrying one signed sample.
// Depends on tma_pkg for the default sample width.
interface tma_sample_if #(
    parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/tma_mean_if.sv =====
// Output request channel carrying one signed mean.
// Depends on tma_pkg for the default sample width.
interface tma_mean_if #(
    parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mean;

    modport source (output valid, output mean, input ready);
    modport sink   (input valid, input mean, output ready);
endinterface

// ===== rtl/tma_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/trimmed_moving_average_top.sv =====
// Trimmed moving average: the top level with control, sweep and divider.
// Depends on tma_pkg, tma_sample_if, tma_mean_if, tma_ram and the macro header.
//
// Usage:
//   i_in carries one signed sample per request; o_out returns one signed mean
//   per sample. The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets
//   the window length (register 0, clamped to 5..DEPTH) and the trim mode
//   (register 1); write it only while the block is idle.
//   Each sample is written into the ring memory, then the window entries are
//   read back one per cycle through the single read port, summed and their
//   largest and smallest tracked; a restoring divider then forms the SUM_W-bit
//   quotient, one quotient bit per cycle (SUM_W = SAMPLE_BITS + log2(DEPTH) +
//   1, 22 at the defaults). A new request is taken only once the previous mean
//   has moved to the output register, so one sample is in work at a time.
//   A finished mean sits in an output register; the block takes the next
//   sample while it waits, and holds the following result until it is taken.
//   Reset returns the length to 16, plain mode, write index zero and an empty
//   ring: a fill count marks entries never written, which read as zero, so no
//   clearing pass is needed.
`include "trimmed_moving_average_top_macros.svh"

module trimmed_moving_average_top #(
    parameter int DEPTH       = tma_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  tma_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [tma_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tma_sample_if.sink                     i_in,
    tma_mean_if.source                     o_out
);
    localparam int AW     = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH) + 1;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int RST_LEN_CL = (tma_pkg::RESET_LENGTH < tma_pkg::MIN_LENGTH) ?
        tma_pkg::MIN_LENGTH : tma_pkg::RESET_LENGTH;
    localparam int RST_LEN = (RST_LEN_CL > DEPTH) ? DEPTH : RST_LEN_CL;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Control and configuration registers
    logic [1:0]       r_state;
    logic [LEN_W-1:0] r_len;
    logic             r_trim;
    logic [AW-1:0]    r_widx;
    logic [LEN_W-1:0] r_fill;
    logic [LEN_W-1:0] r_cnt;
    logic             r_pend;
    logic [LEN_W-1:0] r_pidx;
    logic [DCNT_W-1:0] r_dcnt;
    logic             r_ovalid;

    // Datapath registers
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SAMPLE_BITS-1:0] r_hi;
    logic signed [SAMPLE_BITS-1:0] r_lo;
    logic [SUM_W-1:0]              r_quo;
    logic [LEN_W-1:0]              r_rem;
    logic [LEN_W-1:0]              r_div;
    logic                          r_neg;
    logic signed [SAMPLE_BITS-1:0] r_mean;

    logic                          in_acc;
    logic                          out_free;
    logic [LEN_W-1:0]              n_len;
    logic [AW-1:0]                 wr_idx;
    logic [LEN_W-1:0]              wr_next;
    logic [AW-1:0]                 n_widx;
    logic [LEN_W-1:0]              n_fill;
    logic [SAMPLE_BITS-1:0]        ram_q;
    logic signed [SAMPLE_BITS-1:0] entry;
    logic signed [SUM_W-1:0]       num;
    logic [SUM_W-1:0]              mag;
    logic [LEN_W:0]                rem_sh;
    logic                          rem_ge;
    logic [LEN_W-1:0]              rem_sub;
    logic [SAMPLE_BITS-1:0]        quo_lo;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign out_free    = !r_ovalid || o_out.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.mean  = r_mean;

    // Clamp a written window length to the legal range
    always_comb begin
        if (int'(i_cfg_data) < tma_pkg::MIN_LENGTH) begin
            n_len = LEN_W'(tma_pkg::MIN_LENGTH);
        end else if (int'(i_cfg_data) > DEPTH) begin
            n_len = LEN_W'(DEPTH);
        end else begin
            n_len = LEN_W'(i_cfg_data);
        end
    end

    // Write slot, next write index and fill count for an accepted request
    always_comb begin
        wr_idx  = (LEN_W'(r_widx) >= r_len) ? '0 : r_widx;
        wr_next = LEN_W'(wr_idx) + LEN_W'(1);
        n_widx  = (wr_next >= r_len) ? '0 : wr_next[AW-1:0];
        n_fill  = (wr_next > r_fill) ? wr_next : r_fill;
    end

    // Ring memory; the accepted sample is written before the sweep's first read
    tma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (wr_idx),
        .i_wdata (i_in.sample),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_q)
    );

    // Entries beyond the fill count were never written and read as zero
    assign entry = (r_pidx < r_fill) ? $signed(ram_q) : '0;

    // Numerator and its magnitude for the divider
    always_comb begin
        if (r_trim) begin
            num = r_sum - SUM_W'(r_hi) - SUM_W'(r_lo);
        end else begin
            num = r_sum;
        end
        mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
    end

    // One restoring division step
    always_comb begin
        rem_sh  = {r_rem, r_quo[SUM_W-1]};
        rem_ge  = (rem_sh >= {1'b0, r_div});
        rem_sub = LEN_W'(rem_sh - {1'b0, r_div});
        quo_lo  = r_quo[SAMPLE_BITS-1:0];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(RST_LEN);
            r_trim <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tma_pkg::REG_WINDOW_LENGTH: r_len  <= n_len;
                tma_pkg::REG_TRIM_MODE:     r_trim <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer: accept, sweep the window, divide, hand over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_widx   <= '0;
            r_fill   <= '0;
            r_cnt    <= '0;
            r_pend   <= 1'b0;
            r_pidx   <= '0;
            r_dcnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_widx  <= n_widx;
                        r_fill  <= n_fill;
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_cnt < r_len) begin
                        r_pend <= 1'b1;
                        r_pidx <= r_cnt;
                        r_cnt  <= r_cnt + LEN_W'(1);
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_dcnt  <= DCNT_W'(SUM_W);
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                    if (r_dcnt == DCNT_W'(1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output valid: raise on a finished mean, drop once it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Accumulate sum and extremes, load and run the divider, form the mean
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sum <= '0;
            r_hi  <= i_in.sample;
            r_lo  <= i_in.sample;
        end else if (r_state == ST_READ && r_pend) begin
            r_sum <= r_sum + SUM_W'(entry);
            if (entry > r_hi) begin
                r_hi <= entry;
            end
            if (entry < r_lo) begin
                r_lo <= entry;
            end
        end
        if (r_state == ST_READ && r_cnt >= r_len && !r_pend) begin
            r_quo <= mag;
            r_neg <= num[SUM_W-1];
            r_rem <= '0;
            r_div <= r_trim ? (r_len - LEN_W'(tma_pkg::TRIMMED_COUNT)) : r_len;
        end else if (r_state == ST_DIV) begin
            r_rem <= rem_ge ? rem_sub : rem_sh[LEN_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
        end
        if (r_state == ST_DONE && out_free) begin
            r_mean <= r_neg ? $signed(SAMPLE_BITS'(-quo_lo)) : $signed(quo_lo);
        end
    end

    // Checks on the sequencer and divider
    `TMA_ASSERT_NEXT(a_accept_sweeps, i_clk, i_rst_n, in_acc, r_state == ST_READ, "accepted request did not start the sweep")
    `TMA_ASSERT_NOW(a_len_range, i_clk, i_rst_n, 1'b1, r_len >= LEN_W'(tma_pkg::MIN_LENGTH) && r_len <= LEN_W'(DEPTH), "window length out of range")
    `TMA_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_div, "divider remainder not below divisor")
    `TMA_ASSERT_NOW(a_pend_in_sweep, i_clk, i_rst_n, r_pend, r_state == ST_READ, "read pending outside the sweep")
endmodule
